FILE: src/btr_pkg.sv
package btr_pkg;

  localparam int NODE_CAPACITY_DEF = 128;
  localparam int ENTRY_WIDTH_DEF = 32;
  localparam logic [7:0] ENTRY_LIMIT_RST = 8'd128;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_REBAL  = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_TARGET = 2'd2,
    ST_INDEX  = 2'd3
  } status_t;

  localparam logic [1:0] NODE_LEFT   = 2'd0;
  localparam logic [1:0] NODE_CENTER = 2'd1;
  localparam logic [1:0] NODE_RIGHT  = 2'd2;
  localparam logic [1:0] NODE_NONE   = 2'd3;

  typedef struct packed {
    logic load;
    logic exec_op;
    logic read_resp;
    logic fail_resp;
    logic gather;
    logic pos_clr;
    logic scatter;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic tgt_fail;
    logic total_zero;
    logic pos_last;
  } stat_t;

endpackage

FILE: src/btr_ctrl.sv
module btr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     action,
  input  btr_pkg::stat_t stat,
  output btr_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);
  import btr_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_EXEC     = 12'b000000000010,
    S_RD_ISSUE = 12'b000000000100,
    S_RD_DONE  = 12'b000000001000,
    S_CALC1    = 12'b000000010000,
    S_CALC2    = 12'b000000100000,
    S_CALC3    = 12'b000001000000,
    S_CHECK    = 12'b000010000000,
    S_GATHER   = 12'b000100000000,
    S_GFLUSH   = 12'b001000000000,
    S_SCATTER  = 12'b010000000000,
    S_SFLUSH   = 12'b100000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   respond;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= respond;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (action)
            ACT_READ:  state_next = S_RD_ISSUE;
            ACT_REBAL: state_next = S_CALC1;
            default:   state_next = S_EXEC;
          endcase
        end
      end
      S_EXEC: begin
        cmd.exec_op = 1'b1;
        state_next  = S_IDLE;
      end
      S_RD_ISSUE: state_next = S_RD_DONE;
      S_RD_DONE: begin
        cmd.read_resp = 1'b1;
        state_next    = S_IDLE;
      end
      S_CALC1: state_next = S_CALC2;
      S_CALC2: state_next = S_CALC3;
      S_CALC3: state_next = S_CHECK;
      S_CHECK: begin
        if (stat.tgt_fail) begin
          cmd.fail_resp = 1'b1;
          state_next    = S_IDLE;
        end else if (stat.total_zero) begin
          state_next = S_SFLUSH;
        end else begin
          state_next = S_GATHER;
        end
      end
      S_GATHER: begin
        cmd.gather = 1'b1;
        if (stat.pos_last) begin
          state_next = S_GFLUSH;
        end
      end
      S_GFLUSH: begin
        cmd.pos_clr = 1'b1;
        state_next  = S_SCATTER;
      end
      S_SCATTER: begin
        cmd.scatter = 1'b1;
        if (stat.pos_last) begin
          state_next = S_SFLUSH;
        end
      end
      S_SFLUSH: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign respond = cmd.exec_op | cmd.read_resp | cmd.fail_resp | cmd.commit;
  assign busy    = (state != S_IDLE);

endmodule

FILE: src/btr_datapath.sv
module btr_datapath #(
  parameter int NODE_CAPACITY = btr_pkg::NODE_CAPACITY_DEF,
  parameter int ENTRY_WIDTH   = btr_pkg::ENTRY_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     action,
  input  logic [1:0]     node_sel,
  input  logic [6:0]     entry_index,
  input  logic [31:0]    entry_value,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata,
  input  btr_pkg::cmd_t  cmd,
  output btr_pkg::stat_t stat,
  output logic [1:0]     status,
  output logic [31:0]    read_value,
  output logic [7:0]     left_total,
  output logic [7:0]     center_total,
  output logic [7:0]     right_total
);
  import btr_pkg::*;

  localparam int CNT_W   = $clog2(NODE_CAPACITY + 1);
  localparam int TOT_W   = $clog2(3 * NODE_CAPACITY + 1);
  localparam int AW      = $clog2(NODE_CAPACITY);
  localparam int MDEPTH  = 3 * NODE_CAPACITY;
  localparam int MAW     = $clog2(MDEPTH);
  localparam int IDX_W   = 7;
  localparam int ICMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int LIM_W   = 8;
  localparam int CMP_W   = (TOT_W > LIM_W) ? TOT_W : LIM_W;
  localparam int RK      = TOT_W + 1;
  localparam int PW      = TOT_W + RK;
  localparam int Q3_W    = TOT_W + 2;
  localparam int RECIP_I = ((1 << RK) + 2) / 3;
  localparam logic [RK-1:0]    RECIP   = RK'(RECIP_I);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(NODE_CAPACITY);

  logic [7:0]             entry_limit;
  action_t                act_r;
  logic [1:0]             sel_r;
  logic [IDX_W-1:0]       idx_r;
  logic [ENTRY_WIDTH-1:0] val_r;

  logic [CNT_W-1:0] cnt_left, cnt_center, cnt_right;
  logic [CNT_W-1:0] cnt_left_next, cnt_center_next, cnt_right_next;

  logic [TOT_W-1:0] total;
  logic [PW-1:0]    prod;
  logic [TOT_W-1:0] tr, tl, tc;
  logic [TOT_W-1:0] tr_next, tl_next, tc_next;
  logic [TOT_W-1:0] q_raw;
  logic [Q3_W-1:0]  q3, tr3;

  logic [MAW-1:0]   pos;
  logic [TOT_W-1:0] pos_x;
  logic             g_vld;
  logic [MAW-1:0]   g_pos;
  logic [1:0]       g_node;
  logic             s_vld;
  logic [1:0]       s_node;
  logic [AW-1:0]    s_idx;

  logic [1:0]       src_node, dst_node;
  logic [AW-1:0]    src_idx, dst_idx;
  logic [TOT_W-1:0] sum_lc, sum_tlc;

  logic [ENTRY_WIDTH-1:0] node_rdata [3];
  logic [ENTRY_WIDTH-1:0] mrg_rdata;
  logic [ENTRY_WIDTH-1:0] g_wdata;
  logic [ENTRY_WIDTH-1:0] sel_rdata;
  logic [ENTRY_WIDTH-1:0] node_wdata;
  logic [AW-1:0]          node_waddr;
  logic [AW-1:0]          node_raddr;
  logic [2:0]             node_we;

  logic [CNT_W-1:0] sel_cnt;
  status_t          app_status, rd_status, status_next;
  logic             app_ok, rd_ok, respond;
  logic [31:0]      read_value_next;

  // node selection for the latched selector
  always_comb begin
    case (sel_r)
      NODE_LEFT: begin
        sel_cnt   = cnt_left;
        sel_rdata = node_rdata[0];
      end
      NODE_CENTER: begin
        sel_cnt   = cnt_center;
        sel_rdata = node_rdata[1];
      end
      NODE_RIGHT: begin
        sel_cnt   = cnt_right;
        sel_rdata = node_rdata[2];
      end
      default: begin
        sel_cnt   = '0;
        sel_rdata = '0;
      end
    endcase
  end

  always_comb begin
    if (sel_r == NODE_NONE) begin
      app_status = ST_INDEX;
    end else if (sel_cnt >= CAP_CNT) begin
      app_status = ST_FULL;
    end else begin
      app_status = ST_OK;
    end
    if (sel_r == NODE_NONE || ICMP_W'(idx_r) >= ICMP_W'(sel_cnt)) begin
      rd_status = ST_INDEX;
    end else begin
      rd_status = ST_OK;
    end
  end

  assign app_ok = (app_status == ST_OK);
  assign rd_ok  = (rd_status == ST_OK);

  // rebalance targets: total/3 by reciprocal with a one-step correction
  assign q_raw = prod[PW-1:RK];
  assign q3    = {1'b0, q_raw, 1'b0} + Q3_W'(q_raw);
  always_comb begin
    tr_next = (q3 > Q3_W'(total)) ? q_raw - 1'b1 : q_raw;
  end
  assign tr3     = {1'b0, tr, 1'b0} + Q3_W'(tr);
  assign tl_next = (tr3 != Q3_W'(total)) ? tr + 1'b1 : tr;
  assign tc_next = total - tl_next - tr;

  assign stat.tgt_fail   = (CMP_W'(tl) > CMP_W'(entry_limit)) ||
                           (CMP_W'(tr) > CMP_W'(entry_limit));
  assign stat.total_zero = (total == '0);
  assign pos_x           = TOT_W'(pos);
  assign stat.pos_last   = (pos_x == total - 1'b1);

  // gather source and scatter destination of the current position
  assign sum_lc  = TOT_W'(cnt_left) + TOT_W'(cnt_center);
  assign sum_tlc = tl + tc;
  always_comb begin
    if (pos_x < TOT_W'(cnt_left)) begin
      src_node = NODE_LEFT;
      src_idx  = AW'(pos_x);
    end else if (pos_x < sum_lc) begin
      src_node = NODE_CENTER;
      src_idx  = AW'(pos_x - TOT_W'(cnt_left));
    end else begin
      src_node = NODE_RIGHT;
      src_idx  = AW'(pos_x - sum_lc);
    end
    if (pos_x < tl) begin
      dst_node = NODE_LEFT;
      dst_idx  = AW'(pos_x);
    end else if (pos_x < sum_tlc) begin
      dst_node = NODE_CENTER;
      dst_idx  = AW'(pos_x - tl);
    end else begin
      dst_node = NODE_RIGHT;
      dst_idx  = AW'(pos_x - sum_tlc);
    end
  end

  always_comb begin
    case (g_node)
      NODE_LEFT:   g_wdata = node_rdata[0];
      NODE_CENTER: g_wdata = node_rdata[1];
      default:     g_wdata = node_rdata[2];
    endcase
  end

  // node store port muxing
  assign node_raddr = cmd.gather ? src_idx : AW'(idx_r);
  always_comb begin
    node_we    = '0;
    node_waddr = AW'(sel_cnt);
    node_wdata = val_r;
    if (s_vld) begin
      node_waddr = s_idx;
      node_wdata = mrg_rdata;
      case (s_node)
        NODE_LEFT:   node_we = 3'b001;
        NODE_CENTER: node_we = 3'b010;
        default:     node_we = 3'b100;
      endcase
    end else if (cmd.exec_op && act_r == ACT_APPEND && app_ok) begin
      case (sel_r)
        NODE_LEFT:   node_we = 3'b001;
        NODE_CENTER: node_we = 3'b010;
        NODE_RIGHT:  node_we = 3'b100;
        default:     node_we = 3'b000;
      endcase
    end
  end

  always_comb begin
    cnt_left_next   = cnt_left;
    cnt_center_next = cnt_center;
    cnt_right_next  = cnt_right;
    if (cmd.exec_op) begin
      if (act_r == ACT_CLEAR) begin
        cnt_left_next   = '0;
        cnt_center_next = '0;
        cnt_right_next  = '0;
      end else if (act_r == ACT_APPEND && app_ok) begin
        case (sel_r)
          NODE_LEFT:   cnt_left_next   = cnt_left + 1'b1;
          NODE_CENTER: cnt_center_next = cnt_center + 1'b1;
          NODE_RIGHT:  cnt_right_next  = cnt_right + 1'b1;
          default:     cnt_left_next   = cnt_left;
        endcase
      end
    end else if (cmd.commit) begin
      cnt_left_next   = CNT_W'(tl);
      cnt_center_next = CNT_W'(tc);
      cnt_right_next  = CNT_W'(tr);
    end
  end

  always_comb begin
    status_next = ST_OK;
    if (cmd.exec_op && act_r == ACT_APPEND) begin
      status_next = app_status;
    end else if (cmd.read_resp) begin
      status_next = rd_status;
    end else if (cmd.fail_resp) begin
      status_next = ST_TARGET;
    end
  end

  assign read_value_next = (cmd.read_resp && rd_ok) ? 32'(sel_rdata) : 32'd0;
  assign respond = cmd.exec_op | cmd.read_resp | cmd.fail_resp | cmd.commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit <= ENTRY_LIMIT_RST;
      cnt_left    <= '0;
      cnt_center  <= '0;
      cnt_right   <= '0;
      g_vld       <= 1'b0;
      s_vld       <= 1'b0;
    end else begin
      if (cfg_we) begin
        entry_limit <= cfg_wdata;
      end
      cnt_left   <= cnt_left_next;
      cnt_center <= cnt_center_next;
      cnt_right  <= cnt_right_next;
      g_vld      <= cmd.gather;
      s_vld      <= cmd.scatter;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action_t'(action);
      sel_r <= node_sel;
      idx_r <= entry_index;
      val_r <= ENTRY_WIDTH'(entry_value);
      total <= TOT_W'(cnt_left) + TOT_W'(cnt_center) + TOT_W'(cnt_right);
    end
    prod <= PW'(total) * PW'(RECIP);
    tr   <= tr_next;
    tl   <= tl_next;
    tc   <= tc_next;
    if (cmd.load || cmd.pos_clr) begin
      pos <= '0;
    end else if (cmd.gather || cmd.scatter) begin
      pos <= pos + 1'b1;
    end
    g_pos  <= pos;
    g_node <= src_node;
    s_node <= dst_node;
    s_idx  <= dst_idx;
    if (respond) begin
      status       <= status_next;
      read_value   <= read_value_next;
      left_total   <= 8'(cnt_left_next);
      center_total <= 8'(cnt_center_next);
      right_total  <= 8'(cnt_right_next);
    end
  end

  for (genvar n = 0; n < 3; n++) begin : g_node_mem
    logic [ENTRY_WIDTH-1:0] mem [NODE_CAPACITY];
    always_ff @(posedge clk) begin
      if (node_we[n]) begin
        mem[node_waddr] <= node_wdata;
      end
      node_rdata[n] <= mem[node_raddr];
    end
  end

  logic [ENTRY_WIDTH-1:0] mrg [MDEPTH];
  always_ff @(posedge clk) begin
    if (g_vld) begin
      mrg[g_pos] <= g_wdata;
    end
    mrg_rdata <= mrg[pos];
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(g_vld && s_vld))
    else $error("gather and scatter writes overlap");

  a_gather_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.scatter |-> !g_vld)
    else $error("scatter read before gather drained");

  a_fail_keeps_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.fail_resp |=> (cnt_left == $past(cnt_left) && cnt_center == $past(cnt_center) &&
                       cnt_right == $past(cnt_right)))
    else $error("counts changed on rejected rebalance");
`endif

endmodule

FILE: src/btree_three_node_rebalance_top.sv
// Three sibling B-tree nodes with counts; a transaction clears the counts, appends an
// entry, reads an entry, or rebalances the nodes in concatenated order. A transaction
// is taken when start is high and busy is low; its result appears on the output ports
// for exactly one cycle with done high, and the receiver cannot stall it, so it must
// capture the result in that cycle. Busy stays high after acceptance while the operation
// runs: clear and append execute directly, a read issues and then returns, and a rebalance
// computes its targets, checks them against the limit and, if they pass, gathers and scatters
// any entries and commits; a new transaction can be taken in the cycle done is high. The
// rebalance time is set by moving one entry per cycle through the single read port of the
// node stores into a scratch store, then one per cycle back out to the nodes.
module btree_three_node_rebalance_top #(
  parameter int NODE_CAPACITY = btr_pkg::NODE_CAPACITY_DEF,
  parameter int ENTRY_WIDTH   = btr_pkg::ENTRY_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [1:0]  node_sel,
  input  logic [6:0]  entry_index,
  input  logic [31:0] entry_value,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] read_value,
  output logic [7:0]  left_total,
  output logic [7:0]  center_total,
  output logic [7:0]  right_total
);
  import btr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  btr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  btr_datapath #(
    .NODE_CAPACITY (NODE_CAPACITY),
    .ENTRY_WIDTH   (ENTRY_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .action       (action),
    .node_sel     (node_sel),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .stat         (stat),
    .status       (status),
    .read_value   (read_value),
    .left_total   (left_total),
    .center_total (center_total),
    .right_total  (right_total)
  );

endmodule

FILE: bench/btree_three_node_rebalance_top_tb.sv
module btree_three_node_rebalance_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import btr_pkg::*;

  typedef struct {
    action_t     act;
    logic [1:0]  sel;
    logic [6:0]  idx;
    logic [31:0] val;
  } tree_op_t;

  typedef struct {
    status_t     st;
    logic [31:0] rd;
    logic [7:0]  lt;
    logic [7:0]  ct;
    logic [7:0]  rt;
  } tree_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action = ACT_CLEAR;
  logic [1:0]  node_sel = NODE_LEFT;
  logic [6:0]  entry_index = '0;
  logic [31:0] entry_value = '0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        done;
  logic [1:0]  status;
  logic [31:0] read_value;
  logic [7:0]  left_total;
  logic [7:0]  center_total;
  logic [7:0]  right_total;

  btree_three_node_rebalance_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .node_sel     (node_sel),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .status       (status),
    .read_value   (read_value),
    .left_total   (left_total),
    .center_total (center_total),
    .right_total  (right_total)
  );

  tree_op_t   op_q[$];
  tree_resp_t resp_q[$];

  logic [31:0] node_words [3][128];
  int          node_cnt [3];
  int          max_ent;

  logic taken = 1'b0;
  logic idle_on = 1'b1;
  int   errors;
  int   n_xfer, n_rebal, n_refused, n_full, n_badidx, n_reads_ok, n_cfg;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic tree_resp_t tree_apply(tree_op_t op);
    tree_resp_t  r;
    logic [31:0] merged [384];
    int          total, tl, tc, tr, pos;
    r.st = ST_OK;
    r.rd = '0;
    case (op.act)
      ACT_CLEAR: begin
        node_cnt = '{0, 0, 0};
      end
      ACT_APPEND: begin
        if (op.sel == NODE_NONE) begin
          r.st = ST_INDEX;
        end else if (node_cnt[op.sel] >= 128) begin
          r.st = ST_FULL;
        end else begin
          node_words[op.sel][node_cnt[op.sel]] = op.val;
          node_cnt[op.sel]++;
        end
      end
      ACT_REBAL: begin
        total = node_cnt[0] + node_cnt[1] + node_cnt[2];
        tr = total / 3;
        tl = tr + ((tr * 3 != total) ? 1 : 0);
        tc = total - tl - tr;
        if (tl > max_ent || tr > max_ent) begin
          r.st = ST_TARGET;
        end else begin
          pos = 0;
          for (int n = 0; n < 3; n++)
            for (int k = 0; k < node_cnt[n]; k++) merged[pos++] = node_words[n][k];
          for (int k = 0; k < tl; k++) node_words[0][k] = merged[k];
          for (int k = 0; k < tc; k++) node_words[1][k] = merged[tl + k];
          for (int k = 0; k < tr; k++) node_words[2][k] = merged[tl + tc + k];
          node_cnt = '{tl, tc, tr};
        end
      end
      default: begin
        if (op.sel == NODE_NONE || op.idx >= node_cnt[op.sel]) begin
          r.st = ST_INDEX;
        end else begin
          r.rd = node_words[op.sel][op.idx];
        end
      end
    endcase
    r.lt = node_cnt[0][7:0];
    r.ct = node_cnt[1][7:0];
    r.rt = node_cnt[2][7:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endtask

  // driver
  always @(negedge clk) begin
    tree_op_t op;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (op_q.size() > 0 && !(idle_on && $urandom_range(0, 99) < 8)) begin
        op = op_q.pop_front();
        start <= 1'b1;
        action <= op.act;
        node_sel <= op.sel;
        entry_index <= op.idx;
        entry_value <= op.val;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    tree_op_t   op;
    tree_resp_t exp_r;
    if (rst) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (done) begin
        if (resp_q.size() == 0) begin
          errors++;
          $display("%0t: result with no transaction pending, status %0d", $time, status);
        end else begin
          exp_r = resp_q.pop_front();
          check_field("status", 32'(exp_r.st), 32'(status));
          check_field("read_value", exp_r.rd, read_value);
          check_field("left_total", 32'(exp_r.lt), 32'(left_total));
          check_field("center_total", 32'(exp_r.ct), 32'(center_total));
          check_field("right_total", 32'(exp_r.rt), 32'(right_total));
        end
      end
      if (start && !busy) begin
        op.act = action_t'(action);
        op.sel = node_sel;
        op.idx = entry_index;
        op.val = entry_value;
        exp_r = tree_apply(op);
        resp_q.push_back(exp_r);
        n_xfer++;
        if (op.act == ACT_REBAL) n_rebal++;
        if (exp_r.st == ST_TARGET) n_refused++;
        if (exp_r.st == ST_FULL) n_full++;
        if (exp_r.st == ST_INDEX) n_badidx++;
        if (op.act == ACT_READ && exp_r.st == ST_OK) n_reads_ok++;
      end
    end
  end

  function automatic void push_op(action_t a, logic [1:0] s, logic [6:0] i, logic [31:0] v);
    tree_op_t op;
    op.act = a;
    op.sel = s;
    op.idx = i;
    op.val = v;
    op_q.push_back(op);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [6:0] rand_idx();
    if ($urandom_range(0, 99) < 85) return 7'($urandom_range(0, 40));
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [1:0] rand_sel();
    if ($urandom_range(0, 9) == 0) return NODE_NONE;
    return 2'($urandom_range(0, 2));
  endfunction

  function automatic void gen_mix(int n);
    int made, k;
    made = 0;
    while (made < n) begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        repeat ($urandom_range(1, 12)) begin
          push_op(ACT_APPEND, rand_sel(), rand_idx(), rand_word());
          made++;
        end
        push_op(ACT_REBAL, 2'($urandom_range(0, 3)), rand_idx(), $urandom);
        made++;
        repeat ($urandom_range(1, 4)) begin
          push_op(ACT_READ, rand_sel(), rand_idx(), $urandom);
          made++;
        end
      end else if (k < 65) begin
        push_op(ACT_CLEAR, 2'($urandom_range(0, 3)), rand_idx(), $urandom);
        made++;
      end else if (k < 80) begin
        push_op(ACT_READ, rand_sel(), rand_idx(), $urandom);
        made++;
      end else if (k < 90) begin
        push_op(ACT_APPEND, rand_sel(), rand_idx(), rand_word());
        made++;
      end else begin
        push_op(ACT_REBAL, 2'($urandom_range(0, 3)), rand_idx(), $urandom);
        made++;
      end
    end
  endfunction

  task automatic wait_idle();
    while (op_q.size() != 0 || start || resp_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_max(logic [7:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    max_ent = v;
    n_cfg++;
  endtask

  initial begin
    logic [1:0] fsel;
    max_ent = ENTRY_LIMIT_RST;
    node_cnt = '{0, 0, 0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed
    push_op(ACT_CLEAR,  NODE_NONE,   7'd0,   32'h0);
    push_op(ACT_REBAL,  NODE_LEFT,   7'd0,   32'h0);
    push_op(ACT_READ,   NODE_LEFT,   7'd0,   32'h0);
    push_op(ACT_APPEND, NODE_LEFT,   7'd0,   32'h0000_0000);
    push_op(ACT_APPEND, NODE_LEFT,   7'd127, 32'hFFFF_FFFF);
    push_op(ACT_APPEND, NODE_CENTER, 7'd0,   32'hA5A5_A5A5);
    push_op(ACT_APPEND, NODE_RIGHT,  7'd0,   32'h5A5A_5A5A);
    push_op(ACT_APPEND, NODE_RIGHT,  7'd0,   32'h0000_0001);
    push_op(ACT_APPEND, NODE_RIGHT,  7'd0,   32'h8000_0000);
    push_op(ACT_APPEND, NODE_NONE,   7'd0,   32'h1234_5678);
    push_op(ACT_READ,   NODE_NONE,   7'd0,   32'h0);
    push_op(ACT_READ,   NODE_LEFT,   7'd1,   32'h0);
    push_op(ACT_READ,   NODE_RIGHT,  7'd127, 32'h0);
    push_op(ACT_READ,   NODE_LEFT,   7'd2,   32'h0);
    push_op(ACT_REBAL,  NODE_NONE,   7'd5,   32'hDEAD_BEEF);
    push_op(ACT_READ,   NODE_CENTER, 7'd1,   32'h0);
    push_op(ACT_READ,   NODE_RIGHT,  7'd1,   32'h0);
    push_op(ACT_APPEND, NODE_CENTER, 7'd0,   32'h0000_0007);
    push_op(ACT_REBAL,  NODE_LEFT,   7'd0,   32'h0);
    push_op(ACT_READ,   NODE_LEFT,   7'd2,   32'h0);
    push_op(ACT_CLEAR,  NODE_LEFT,   7'd0,   32'h0);
    push_op(ACT_READ,   NODE_LEFT,   7'd0,   32'h0);
    push_op(ACT_APPEND, NODE_LEFT,   7'd0,   32'hCAFE_0001);
    push_op(ACT_APPEND, NODE_LEFT,   7'd0,   32'hCAFE_0002);
    push_op(ACT_REBAL,  NODE_RIGHT,  7'd0,   32'h0);
    push_op(ACT_READ,   NODE_CENTER, 7'd0,   32'h0);

    // zero limit: any nonempty rebalance is refused
    set_max(8'd0);
    gen_mix(60);

    // top limit, no sender gaps, one node driven past full
    set_max(8'd255);
    idle_on = 1'b0;
    fsel = 2'($urandom_range(0, 2));
    push_op(ACT_CLEAR, NODE_LEFT, 7'd0, 32'h0);
    repeat (131) push_op(ACT_APPEND, fsel, rand_idx(), rand_word());
    push_op(ACT_READ, fsel, 7'd127, 32'h0);
    push_op(ACT_REBAL, NODE_LEFT, 7'd0, 32'h0);
    gen_mix(150);
    wait_idle();
    idle_on = 1'b1;

    set_max(8'($urandom_range(1, 60)));
    gen_mix(180);

    set_max(ENTRY_LIMIT_RST);
    gen_mix(120);

    wait_idle();
    repeat (20) @(negedge clk);
    $display("%0d transactions, %0d rebalances (%0d refused on target limit), %0d limit writes",
             n_xfer, n_rebal, n_refused, n_cfg);
    $display("%0d appends to a full node, %0d bad index or selector, %0d good reads",
             n_full, n_badidx, n_reads_ok);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
src/btr_pkg.sv
src/btr_ctrl.sv
src/btr_datapath.sv
src/btree_three_node_rebalance_top.sv
bench/btree_three_node_rebalance_top_tb.sv
